### sv/mec_pkg.sv
`default_nettype none

package mec_pkg;

  // Number formats
  localparam int FRAC_BITS        = 28;
  localparam int COORD_BITS       = FRAC_BITS + 4;
  localparam int STEP_BITS        = FRAC_BITS + 1;
  localparam int PIXEL_INDEX_BITS = 11;
  localparam int COUNT_BITS       = 12;
  localparam int PROD_BITS        = 2 * COORD_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_RE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_IM     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_RE    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_IM    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = 3'd4;

  // Reset values: -2.0, -1.5, 393216 per pixel, 256 iterations
  localparam logic [COORD_BITS-1:0] LEFT_RE_RST    = COORD_BITS'(-(64'sd1 <<< (FRAC_BITS + 1)));
  localparam logic [COORD_BITS-1:0] TOP_IM_RST     = COORD_BITS'(-(64'sd3 <<< (FRAC_BITS - 1)));
  localparam logic [STEP_BITS-1:0]  STEP_RST       = STEP_BITS'(393216);
  localparam logic [COUNT_BITS-1:0] ITER_LIMIT_RST = COUNT_BITS'(256);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left_re;
    logic signed [COORD_BITS-1:0] top_im;
    logic [STEP_BITS-1:0]         step_re;
    logic [STEP_BITS-1:0]         step_im;
    logic [COUNT_BITS-1:0]        iter_limit;
  } cfg_regs_t;

endpackage

`default_nettype wire

### sv/mec_cfg.sv
`default_nettype none

module mec_cfg
  import mec_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_regs_t                      regs
);

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.left_re    <= LEFT_RE_RST;
      regs_r.top_im     <= TOP_IM_RST;
      regs_r.step_re    <= STEP_RST;
      regs_r.step_im    <= STEP_RST;
      regs_r.iter_limit <= ITER_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEFT_RE:    regs_r.left_re    <= cfg_data[COORD_BITS-1:0];
        REG_TOP_IM:     regs_r.top_im     <= cfg_data[COORD_BITS-1:0];
        REG_STEP_RE:    regs_r.step_re    <= cfg_data[STEP_BITS-1:0];
        REG_STEP_IM:    regs_r.step_im    <= cfg_data[STEP_BITS-1:0];
        REG_ITER_LIMIT: regs_r.iter_limit <= cfg_data[COUNT_BITS-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/mec_mul.sv
`default_nettype none

module mec_mul
  import mec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [COORD_BITS-1:0] op_a,
  input  wire logic [COORD_BITS-1:0] op_b,
  output logic [PROD_BITS-1:0]       prod
);

  logic [PROD_BITS-1:0] prod_r;

  // Unsigned magnitude product, registered
  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

### sv/mandelbrot_escape_time_colorizer.sv
`default_nettype none

// Mandelbrot escape-time evaluator with band colouring.
// Input: pulse start with in_pixel_col / in_pixel_row while busy is low; the
// pixel is taken at that edge. busy stays high until the result is out.
// The pixel maps to c = left_re + col*step_re + i*(top_im + row*step_im),
// Q4.28, saturated. z starts at c and z = z*z + c is repeated until
// |z|^2 >= 4 or the count reaches the iteration limit.
// Output: out_valid is high for one cycle with the count and an RGB colour;
// the receiver has no back-pressure and must take it in that cycle.
// Timing: one 32x32 multiplier is shared by everything. Mapping steps through
// MAP_RE, MAP_IM and MAP_END, each iteration through SQ_RE, SQ_IM, CROSS and
// UPDATE (re^2, im^2, re*im, update), and the final escape test through
// SQ_RE, SQ_IM and CROSS. busy is already low while the result is on the
// ports, so the next pixel is taken at the edge that ends the out_valid cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready, writes take effect on the next edge. Write only while idle.
// Reset: synchronous, active low; the configuration registers return to their
// defaults and the sequencer goes idle. No clearing pass is needed.
module mandelbrot_escape_time_colorizer
  import mec_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [PIXEL_INDEX_BITS-1:0] in_pixel_col,
  input  wire logic [PIXEL_INDEX_BITS-1:0] in_pixel_row,
  output logic                             out_valid,
  output logic [COUNT_BITS-1:0]            out_iteration_count,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int SUM_BITS = PROD_BITS + 2;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MAP_RE  = 3'd1;
  localparam logic [2:0] ST_MAP_IM  = 3'd2;
  localparam logic [2:0] ST_MAP_END = 3'd3;
  localparam logic [2:0] ST_SQ_RE   = 3'd4;
  localparam logic [2:0] ST_SQ_IM   = 3'd5;
  localparam logic [2:0] ST_CROSS   = 3'd6;
  localparam logic [2:0] ST_UPDATE  = 3'd7;

  localparam logic signed [SUM_BITS-1:0] COORD_MAX =
    SUM_BITS'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
  localparam logic signed [SUM_BITS-1:0] COORD_MIN = -COORD_MAX - SUM_BITS'(1);
  localparam logic [PROD_BITS:0] FOUR = (PROD_BITS + 1)'(1) << (2 * FRAC_BITS + 2);

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [COORD_BITS-1:0] res;
    if (v > COORD_MAX) res = COORD_MAX[COORD_BITS-1:0];
    else if (v < COORD_MIN) res = COORD_MIN[COORD_BITS-1:0];
    else res = v[COORD_BITS-1:0];
    return res;
  endfunction

  function automatic logic [23:0] band_colour(
    input logic [COUNT_BITS-1:0] cnt,
    input logic [COUNT_BITS-1:0] lim
  );
    logic [23:0] rgb;
    priority if (cnt == lim) rgb = {8'd0, 8'd0, 8'd0};
    else if ({cnt, 1'b0} > {1'b0, lim}) rgb = {8'd100, 8'd20, 8'd20};
    else if ({cnt, 2'b00} > {2'b00, lim}) rgb = {8'd200, 8'd40, 8'd40};
    else if ((COUNT_BITS + 9)'(cnt) * (COUNT_BITS + 9)'(400) >
             (COUNT_BITS + 9)'(lim) * (COUNT_BITS + 9)'(51))
      rgb = {8'd255, 8'd127, 8'd127};
    else rgb = {8'd255, 8'd255, 8'd255};
    return rgb;
  endfunction

  cfg_regs_t regs;

  mec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  logic [2:0]                    state_r, state_nxt;
  logic [PIXEL_INDEX_BITS-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic signed [COORD_BITS-1:0]  cre_r, cre_nxt, cim_r, cim_nxt;
  logic signed [COORD_BITS-1:0]  re_r, re_nxt, im_r, im_nxt;
  logic [PROD_BITS-1:0]          sr_r, sr_nxt, si_r, si_nxt;
  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0]         out_count_r, out_count_nxt;
  logic [23:0]                   out_rgb_r, out_rgb_nxt;

  logic [COORD_BITS-1:0]         abs_re, abs_im, mul_a, mul_b;
  logic [PROD_BITS-1:0]          prod;
  logic signed [SUM_BITS-1:0]    map_sum_re, map_sum_im;
  logic signed [PROD_BITS:0]     sq_diff, cross_signed;
  logic signed [SUM_BITS-1:0]    upd_re, upd_im;
  logic                          escape;

  assign abs_re = re_r[COORD_BITS-1] ? COORD_BITS'(-re_r) : COORD_BITS'(re_r);
  assign abs_im = im_r[COORD_BITS-1] ? COORD_BITS'(-im_r) : COORD_BITS'(im_r);

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_MAP_RE: begin
        mul_a = COORD_BITS'(col_r);
        mul_b = COORD_BITS'(regs.step_re);
      end
      ST_MAP_IM: begin
        mul_a = COORD_BITS'(row_r);
        mul_b = COORD_BITS'(regs.step_im);
      end
      ST_SQ_RE: begin
        mul_a = abs_re;
        mul_b = abs_re;
      end
      ST_SQ_IM: begin
        mul_a = abs_im;
        mul_b = abs_im;
      end
      ST_CROSS: begin
        mul_a = abs_re;
        mul_b = abs_im;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mec_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Pixel mapping: start + index*step, product is never negative
  assign map_sum_re = SUM_BITS'(regs.left_re) + $signed({2'b00, prod});
  assign map_sum_im = SUM_BITS'(regs.top_im) + $signed({2'b00, prod});

  // Escape test on the exact squares: re^2 held, im^2 on the multiplier output
  assign escape = ({1'b0, sr_r} + {1'b0, prod}) >= FOUR;

  // Next iterate: floor((re^2 - im^2) / 2^F) and floor(2*re*im / 2^F)
  assign sq_diff      = $signed({1'b0, sr_r}) - $signed({1'b0, si_r});
  assign cross_signed = (re_r[COORD_BITS-1] ^ im_r[COORD_BITS-1]) ?
                        -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign upd_re = SUM_BITS'(sq_diff >>> FRAC_BITS) + SUM_BITS'(cre_r);
  assign upd_im = SUM_BITS'(cross_signed >>> (FRAC_BITS - 1)) + SUM_BITS'(cim_r);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_rgb_nxt   = out_rgb_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          col_nxt   = in_pixel_col;
          row_nxt   = in_pixel_row;
          state_nxt = ST_MAP_RE;
        end
      end
      ST_MAP_RE: begin
        state_nxt = ST_MAP_IM;
      end
      ST_MAP_IM: begin
        cre_nxt   = sat_coord(map_sum_re);
        re_nxt    = sat_coord(map_sum_re);
        state_nxt = ST_MAP_END;
      end
      ST_MAP_END: begin
        cim_nxt   = sat_coord(map_sum_im);
        im_nxt    = sat_coord(map_sum_im);
        count_nxt = '0;
        state_nxt = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        state_nxt = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        sr_nxt    = prod;
        state_nxt = ST_CROSS;
      end
      ST_CROSS: begin
        si_nxt = prod;
        // stop at the limit or once outside radius 2
        if (count_r >= regs.iter_limit || escape) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_rgb_nxt   = band_colour(count_r, regs.iter_limit);
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        re_nxt    = sat_coord(upd_re);
        im_nxt    = sat_coord(upd_im);
        count_nxt = count_r + COUNT_BITS'(1);
        state_nxt = ST_SQ_RE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    cre_r       <= cre_nxt;
    cim_r       <= cim_nxt;
    re_r        <= re_nxt;
    im_r        <= im_nxt;
    sr_r        <= sr_nxt;
    si_r        <= si_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
    out_rgb_r   <= out_rgb_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_red             = out_rgb_r[23:16];
  assign out_green           = out_rgb_r[15:8];
  assign out_blue            = out_rgb_r[7:0];

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import mec_pkg::*;
();

  // One result per pixel: the iteration count and the band colour
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
  } pixel_shade_t;

  // One directed probe: the view it needs, the pixel, and optionally the
  // shade typed in by hand (otherwise the predictor supplies it)
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0]    left_re;
    logic [CFG_DATA_BITS-1:0]    top_im;
    logic [STEP_BITS-1:0]        step_re;
    logic [STEP_BITS-1:0]        step_im;
    logic [COUNT_BITS-1:0]       iter_limit;
    logic [PIXEL_INDEX_BITS-1:0] col;
    logic [PIXEL_INDEX_BITS-1:0] row;
    logic                        known;
    pixel_shade_t                shade;
  } probe_t;

  // Register indexes past the last real register; writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST = REG_ITER_LIMIT + 3'd1;

  localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint COORD_LO = -COORD_HI - 64'sd1;
  // 4.0 with the doubled fraction of an exact square
  localparam logic [64:0] RADIUS_SQ = 65'd1 << (2 * FRAC_BITS + 2);

  localparam logic [CFG_DATA_BITS-1:0] COORD_MIN_W = 32'h8000_0000;
  localparam logic [CFG_DATA_BITS-1:0] COORD_MAX_W = 32'h7FFF_FFFF;
  localparam logic [STEP_BITS-1:0]     UNIT_STEP   = 29'h1000_0000;
  localparam logic [CFG_DATA_BITS-1:0] BAND_LEFT   = 32'h0420_0000;  // just right of 0.25
  localparam logic [STEP_BITS-1:0]     BAND_STEP   = 29'h0001_0000;
  localparam pixel_shade_t             SHADE_TBD   = '0;

  // Random views: left edge in [-2.5, 0.5], top edge in [-1.5, 1.5]
  localparam int          REGION_RE_LO = -671088640;
  localparam int          REGION_IM_LO = -402653184;
  localparam int unsigned REGION_SPAN  = 805306368;
  localparam int unsigned REGION_STEP  = 524288;

  localparam int PROBE_COUNT = 19;
  localparam probe_t PROBES [PROBE_COUNT] = '{
    // Reset view: corner outside radius 2, far corner, origin, c = -1.25 on the real axis, c = -2
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, ITER_LIMIT_RST, 11'd0, 11'd0,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, ITER_LIMIT_RST, 11'd2047, 11'd2047,
      1'b0, SHADE_TBD},
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, ITER_LIMIT_RST, 11'd1365, 11'd1024,
      1'b1, '{12'd256, 8'd0, 8'd0, 8'd0}},
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, ITER_LIMIT_RST, 11'd512, 11'd1024,
      1'b0, SHADE_TBD},
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, ITER_LIMIT_RST, 11'd0, 11'd1024,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    // Limit of one
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, 12'd1, 11'd1365, 11'd1024,
      1'b1, '{12'd1, 8'd0, 8'd0, 8'd0}},
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, 12'd1, 11'd0, 11'd0,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    // Limit of zero: nothing iterates, always black
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, 12'd0, 11'd1365, 11'd1024,
      1'b1, '{12'd0, 8'd0, 8'd0, 8'd0}},
    '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, 12'd0, 11'd2047, 11'd0,
      1'b1, '{12'd0, 8'd0, 8'd0, 8'd0}},
    // Extreme origin and unit steps: the far corner saturates the mapping
    '{COORD_MIN_W, COORD_MAX_W, UNIT_STEP, UNIT_STEP, 12'd4095, 11'd0, 11'd0,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    '{COORD_MIN_W, COORD_MAX_W, UNIT_STEP, UNIT_STEP, 12'd4095, 11'd2047, 11'd2047,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    '{COORD_MIN_W, COORD_MAX_W, UNIT_STEP, UNIT_STEP, 12'd4095, 11'd8, 11'd0,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    // c = 0 never escapes: the full limit; an extreme origin escapes at once
    '{32'h0, 32'h0, 29'h0, 29'h0, 12'd4095, 11'd2047, 11'd2047,
      1'b1, '{12'd4095, 8'd0, 8'd0, 8'd0}},
    '{COORD_MAX_W, COORD_MIN_W, 29'h0, 29'h0, 12'd4095, 11'd1234, 11'd777,
      1'b1, '{12'd0, 8'd255, 8'd255, 8'd255}},
    // Real axis just past the cusp: slow escapes spread over every band
    '{BAND_LEFT, 32'h0, BAND_STEP, 29'h0, 12'd40, 11'd0, 11'd1000,
      1'b0, SHADE_TBD},
    '{BAND_LEFT, 32'h0, BAND_STEP, 29'h0, 12'd40, 11'd200, 11'd3,
      1'b0, SHADE_TBD},
    '{BAND_LEFT, 32'h0, BAND_STEP, 29'h0, 12'd40, 11'd600, 11'd2047,
      1'b0, SHADE_TBD},
    '{BAND_LEFT, 32'h0, BAND_STEP, 29'h0, 12'd40, 11'd1200, 11'd0,
      1'b0, SHADE_TBD},
    '{BAND_LEFT, 32'h0, BAND_STEP, 29'h0, 12'd40, 11'd2047, 11'd512,
      1'b0, SHADE_TBD}
  };

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        start        = 1'b0;
  logic [PIXEL_INDEX_BITS-1:0] in_pixel_col = '0;
  logic [PIXEL_INDEX_BITS-1:0] in_pixel_row = '0;
  logic                        cfg_valid    = 1'b0;
  logic [CFG_INDEX_BITS-1:0]   cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_data     = '0;
  logic                        busy;
  logic                        out_valid;
  logic [COUNT_BITS-1:0]       out_iteration_count;
  logic [7:0]                  out_red;
  logic [7:0]                  out_green;
  logic [7:0]                  out_blue;
  logic                        cfg_ready;

  // Our own copy of the registers, updated on every accepted write
  cfg_regs_t    view = '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, STEP_RST, ITER_LIMIT_RST};
  pixel_shade_t shades_due [$];
  int           faults = 0;

  mandelbrot_escape_time_colorizer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_col        (in_pixel_col),
    .in_pixel_row        (in_pixel_row),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // Origin plus index times step, exact, then clamped to the coordinate range
  function automatic longint pixel_to_axis(input logic signed [COORD_BITS-1:0] origin,
                                           input logic [STEP_BITS-1:0] step,
                                           input logic [PIXEL_INDEX_BITS-1:0] idx);
    longint base;
    longint offset;
    base   = longint'(origin);
    offset = longint'(idx);
    offset = offset * longint'(step);
    return clamp_coord(base + offset);
  endfunction

  // Escape-time count and band colour of one pixel under the current view
  function automatic pixel_shade_t predict_shade(input logic [PIXEL_INDEX_BITS-1:0] col,
                                                 input logic [PIXEL_INDEX_BITS-1:0] row);
    longint       c_re, c_im, z_re, z_im, sq_re, sq_im, re_im;
    logic [64:0]  mag2;
    int unsigned  steps, limit;
    pixel_shade_t shade;
    c_re  = pixel_to_axis(view.left_re, view.step_re, col);
    c_im  = pixel_to_axis(view.top_im, view.step_im, row);
    z_re  = c_re;
    z_im  = c_im;
    limit = 32'(view.iter_limit);
    steps = 0;
    while (steps < limit) begin
      sq_re = z_re * z_re;
      sq_im = z_im * z_im;
      mag2  = 65'(sq_re) + 65'(sq_im);
      if (mag2 >= RADIUS_SQ) break;
      re_im = z_re * z_im;
      // Arithmetic shifts floor towards minus infinity; 2*re*im folds into the shift
      z_re  = clamp_coord(((sq_re - sq_im) >>> FRAC_BITS) + c_re);
      z_im  = clamp_coord((re_im >>> (FRAC_BITS - 1)) + c_im);
      steps++;
    end
    shade.count = steps[COUNT_BITS-1:0];
    if (steps == limit)
      {shade.red, shade.green, shade.blue} = {8'd0, 8'd0, 8'd0};
    else if (steps * 2 > limit)
      {shade.red, shade.green, shade.blue} = {8'd100, 8'd20, 8'd20};
    else if (steps * 4 > limit)
      {shade.red, shade.green, shade.blue} = {8'd200, 8'd40, 8'd40};
    else if (steps * 400 > limit * 51)
      {shade.red, shade.green, shade.blue} = {8'd255, 8'd127, 8'd127};
    else
      {shade.red, shade.green, shade.blue} = {8'd255, 8'd255, 8'd255};
    return shade;
  endfunction

  // Hold valid until the transfer, then track the register locally.
  // Valid is left high; the caller drops it after the last write of a batch.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEFT_RE:    view.left_re    = data;
      REG_TOP_IM:     view.top_im     = data;
      REG_STEP_RE:    view.step_re    = data[STEP_BITS-1:0];
      REG_STEP_IM:    view.step_im    = data[STEP_BITS-1:0];
      REG_ITER_LIMIT: view.iter_limit = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Drop start and wait until every outstanding pixel has come back
  task automatic drain_pixels();
    start <= 1'b0;
    do @(posedge clk); while (shades_due.size() != 0);
  endtask

  // Write every register with the block idle; scramble fills the unused upper
  // data bits with noise, which the narrow registers must drop
  task automatic load_view(input logic [CFG_DATA_BITS-1:0] left, top,
                           input logic [STEP_BITS-1:0] sre, sim,
                           input logic [COUNT_BITS-1:0] lim, input bit scramble);
    logic [CFG_DATA_BITS-1:0] pad;
    drain_pixels();
    pad = scramble ? $urandom : '0;
    write_reg(REG_LEFT_RE, left);
    write_reg(REG_TOP_IM, top);
    write_reg(REG_STEP_RE, {pad[CFG_DATA_BITS-STEP_BITS-1:0], sre});
    write_reg(REG_STEP_IM, {pad[CFG_DATA_BITS-1:STEP_BITS], sim});
    write_reg(REG_ITER_LIMIT, {pad[CFG_DATA_BITS-COUNT_BITS-1:0], lim});
    // A stray write to an unused index must leave the view untouched
    write_reg(REG_UNUSED_FIRST + CFG_INDEX_BITS'($urandom_range(0, 2)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Present a pixel, hold start until the transfer, then log what it should give.
  // Start stays high; the caller decides whether to drop it.
  task automatic send_pixel(input logic [PIXEL_INDEX_BITS-1:0] col, row,
                            input pixel_shade_t shade);
    start        <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do @(posedge clk); while (busy);
    shades_due = {shades_due, shade};
  endtask

  // Every strobed result must match the oldest outstanding pixel
  always @(posedge clk) begin
    pixel_shade_t due;
    if (rst_n && out_valid) begin
      if (shades_due.size() == 0) begin
        $error("result with no pixel outstanding: count %0d", out_iteration_count);
        faults++;
      end else begin
        due = shades_due.pop_front();
        if (out_iteration_count !== due.count) begin
          $error("iteration_count: expected %0d, got %0d", due.count, out_iteration_count);
          faults++;
        end
        if (out_red !== due.red) begin
          $error("red: expected %0d, got %0d", due.red, out_red);
          faults++;
        end
        if (out_green !== due.green) begin
          $error("green: expected %0d, got %0d", due.green, out_green);
          faults++;
        end
        if (out_blue !== due.blue) begin
          $error("blue: expected %0d, got %0d", due.blue, out_blue);
          faults++;
        end
      end
    end
  end

  initial begin
    probe_t                      p;
    logic [PIXEL_INDEX_BITS-1:0] px_col, px_row;
    logic [CFG_DATA_BITS-1:0]    left, top;
    logic [STEP_BITS-1:0]        sre, sim;
    logic [COUNT_BITS-1:0]       lim;
    int                          items, burst;
    bit                          steady;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed probes; the first ones run on the reset values of the registers
    for (int i = 0; i < PROBE_COUNT; i++) begin
      p = PROBES[i];
      if (p.left_re != view.left_re || p.top_im != view.top_im ||
          p.step_re != view.step_re || p.step_im != view.step_im ||
          p.iter_limit != view.iter_limit) begin
        load_view(p.left_re, p.top_im, p.step_re, p.step_im, p.iter_limit, 1'b0);
      end
      send_pixel(p.col, p.row, p.known ? p.shade : predict_shade(p.col, p.row));
    end

    // Random views. Stage 0 throws the whole origin range and steps up to 1.0 at
    // the mapping, stage 1 uses the reset limit, the rest use small limits to keep runs short.
    for (int stage = 0; stage < 10; stage++) begin
      if (stage == 0) begin
        left  = $urandom;
        top   = $urandom;
        sre   = STEP_BITS'($urandom_range(0, UNIT_STEP));
        sim   = STEP_BITS'($urandom_range(0, UNIT_STEP));
        lim   = COUNT_BITS'($urandom_range(1, 16));
        items = 40;
      end else begin
        left  = REGION_RE_LO + int'($urandom_range(0, REGION_SPAN));
        top   = REGION_IM_LO + int'($urandom_range(0, REGION_SPAN));
        sre   = STEP_BITS'($urandom_range(0, REGION_STEP));
        sim   = STEP_BITS'($urandom_range(0, REGION_STEP));
        lim   = (stage == 1) ? ITER_LIMIT_RST : COUNT_BITS'($urandom_range(1, 64));
        items = (stage == 1) ? 40 : 60;
      end
      load_view(left, top, sre, sim, lim, 1'b1);

      // Some stages stream back to back, the others come in bursts with gaps
      steady = ($urandom_range(0, 3) == 0);
      burst  = $urandom_range(1, 16);
      for (int k = 0; k < items; k++) begin
        if (k > 0) begin
          if ($urandom_range(0, 39) == 0) begin
            drain_pixels();
          end else if (!steady && burst == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst = $urandom_range(1, 16);
          end else if (burst > 0) begin
            burst--;
          end
        end
        px_col = PIXEL_INDEX_BITS'($urandom_range(0, 2047));
        px_row = PIXEL_INDEX_BITS'($urandom_range(0, 2047));
        send_pixel(px_col, px_row, predict_shade(px_col, px_row));
      end
    end

    // Let the last pixel come back, then watch for stray strobes
    drain_pixels();
    repeat (40) @(posedge clk);
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
